// ===== rtl/pfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfsa_pkg
// Types, constants and helper functions shared by the pair force scatter-accumulate block.
// ----------------------------------------------------------------------------
package pfsa_pkg;

   localparam int MAX_SLOTS    = 256;
   localparam int MAX_CHANNELS = 8;
   localparam int NUM_TYPES    = 4;
   localparam int SLOT_W       = 8;
   localparam int CH_W         = 3;
   localparam int TYPE_W       = 2;
   localparam int COEF_W       = TYPE_W + CH_W;

   localparam logic [1:0] MODE_COEF = 2'd0;
   localparam logic [1:0] MODE_GRAD = 2'd1;
   localparam logic [1:0] MODE_PAIR = 2'd2;
   localparam logic [1:0] MODE_READ = 2'd3;

   localparam logic signed [31:0] Q_ONE   = 32'sd65536;
   localparam logic signed [31:0] LOG2E_Q = 32'sd94548;
   localparam logic signed [31:0] EXP_LIM = 32'sd4194304;

   typedef struct packed {
      logic [1:0]         mode;
      logic [1:0]         neighbor_type;
      logic [2:0]         channel;
      logic signed [31:0] value_a;
      logic signed [31:0] value_b;
      logic signed [31:0] deriv_x;
      logic signed [31:0] deriv_y;
      logic signed [31:0] deriv_z;
      logic [7:0]         central_slot;
      logic [7:0]         neighbor_slot;
      logic               pair_valid;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic               saturated;
   } rsp_word_type;

   function automatic logic [17:0] exp2_lut(input logic [4:0] j);
      logic [17:0] v;
      case (j)
         5'd0:  v = 18'd65536;
         5'd1:  v = 18'd68438;
         5'd2:  v = 18'd71468;
         5'd3:  v = 18'd74632;
         5'd4:  v = 18'd77936;
         5'd5:  v = 18'd81386;
         5'd6:  v = 18'd84990;
         5'd7:  v = 18'd88752;
         5'd8:  v = 18'd92682;
         5'd9:  v = 18'd96785;
         5'd10: v = 18'd101070;
         5'd11: v = 18'd105545;
         5'd12: v = 18'd110218;
         5'd13: v = 18'd115098;
         5'd14: v = 18'd120194;
         5'd15: v = 18'd125515;
         5'd16: v = 18'd131072;
         default: v = 18'd0;
      endcase
      return v;
   endfunction

   // floor(p / 2^16) clamped to signed 32 bits
   function automatic logic signed [31:0] q_sat(input logic signed [63:0] p);
      logic signed [47:0] s;
      s = p[63:16];
      if (s > 48'sh7FFFFFFF)       return 32'sh7FFFFFFF;
      else if (s < -48'sh80000000) return 32'sh80000000;
      else                         return s[31:0];
   endfunction

endpackage

// ===== rtl/pair_force_scatter_accumulate.sv =====
// ----------------------------------------------------------------------------
// pair_force_scatter_accumulate
// Two-body force scatter for a learned potential, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel | ports                         | handshake
//  req     | start, busy, req_word         | taken when start && !busy
//  rsp     | rsp_strobe, rsp_word          | one cycle, no back-pressure
//  csr     | csr_we, csr_wdata             | written when csr_we
//
// Busy covers every word: loads and padding pairs, reads, and a pair's loop
// over the channels in use. One 32x32 multiplier is shared by every product.
// The rsp word shows in the cycle after the last busy cycle. After reset the
// force store is cleared one slot a cycle over all 256 slots; busy stays high
// meanwhile.
// The receiver cannot stall; each item gives exactly one rsp word.
module pair_force_scatter_accumulate
   import pfsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word,
   input  logic         csr_we,
   input  logic [3:0]   csr_wdata
);

   localparam logic [4:0] S_CLR   = 5'd0,  S_IDLE  = 5'd1,  S_DISP  = 5'd2,
                          S_RD    = 5'd3,  S_RDW   = 5'd4,  S_CH    = 5'd5,
                          S_TMUL  = 5'd6,  S_T     = 5'd7,  S_YMUL  = 5'd8,
                          S_EXP   = 5'd9,  S_EXPS  = 5'd10, S_WE    = 5'd11,
                          S_P1    = 5'd12, S_P2    = 5'd13, S_P3    = 5'd14,
                          S_DX    = 5'd15, S_DY    = 5'd16, S_DZ    = 5'd17,
                          S_ACC   = 5'd18, S_NRD   = 5'd19, S_NWB   = 5'd20,
                          S_CRD   = 5'd21, S_CWB   = 5'd22, S_DONE  = 5'd23;

   // storage
   logic signed [31:0] alpha_mem [NUM_TYPES*MAX_CHANNELS];
   logic signed [31:0] weight_mem[NUM_TYPES*MAX_CHANNELS];
   logic signed [31:0] grad_mem  [MAX_CHANNELS];
   logic [95:0]        force_mem [MAX_SLOTS];

   logic [4:0]          state_ff, state_in;
   logic [3:0]          chans_ff;
   req_word_type        req_ff;
   logic [CH_W:0]       ch_ff, ch_in;
   logic [SLOT_W-1:0]   clr_ff;
   logic signed [31:0]  alpha_ff, weight_ff, grad_ff;
   logic [95:0]         frd_ff;
   logic signed [63:0]  prod_ff;
   logic signed [47:0]  t_ff;
   logic signed [31:0]  p_ff, e_ff;
   logic signed [34:0]  sum_ff [3];
   logic                sat_ff;
   logic                strobe_ff;
   rsp_word_type        rsp_ff;

   // shared multiplier
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic [3:0]  nch;
   assign nch = (chans_ff > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : chans_ff;

   logic [COEF_W-1:0] cidx;
   assign cidx = {req_ff.neighbor_type, ch_ff[CH_W-1:0]};

   // 1 + t, clamped to 32 bits; t is kept unclamped at 48 bits
   logic signed [48:0] tp_w;
   logic signed [31:0] onep_w;
   assign tp_w   = 49'(t_ff) + 49'(Q_ONE);
   assign onep_w = (tp_w > 49'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                   ((tp_w < -49'sh80000000) ? 32'sh80000000 : signed'(tp_w[31:0]));

   // exp pieces
   logic signed [31:0] y_w, k_w;
   logic [15:0]        f_w;
   logic [17:0]        lo_w, hi_w;
   logic [31:0]        m_w;
   logic signed [31:0] tcl_w;
   assign tcl_w = (t_ff > 48'(EXP_LIM)) ? EXP_LIM :
                  ((t_ff < -48'(EXP_LIM)) ? -EXP_LIM : signed'(t_ff[31:0]));
   assign y_w  = prod_ff[47:16];
   assign k_w  = y_w >>> 16;
   assign f_w  = y_w[15:0];
   assign lo_w = exp2_lut({1'b0, f_w[15:12]});
   assign hi_w = exp2_lut(5'({1'b0, f_w[15:12]} + 5'd1));
   assign m_w  = 32'(lo_w) + 32'((32'(hi_w - lo_w) * 32'(f_w[11:0])) >> 12);

   logic signed [63:0] mexp_w;
   always_comb begin
      mexp_w = '0;
      if (k_w >= 32'sd15)       mexp_w = 64'sh7FFFFFFF;
      else if (k_w >= 32'sd0)   mexp_w = 64'(m_w) << k_w[3:0];
      else if (k_w <= -32'sd32) mexp_w = '0;
      else                      mexp_w = 64'(m_w >> 5'(-k_w));
   end

   // force update arithmetic
   logic signed [35:0] upd_w [3];
   logic               upd_sat;
   logic [95:0]        upd_word;
   logic               nb_phase;
   assign nb_phase = (state_ff == S_NWB);
   always_comb begin
      upd_sat = 1'b0;
      for (int c = 0; c < 3; c++) begin
         upd_w[c] = nb_phase ? 36'(signed'(frd_ff[c*32 +: 32])) + 36'(sum_ff[c])
                             : 36'(signed'(frd_ff[c*32 +: 32])) - 36'(sum_ff[c]);
         if (upd_w[c] > 36'sh7FFFFFFF) begin
            upd_w[c] = 36'sh7FFFFFFF; upd_sat = 1'b1;
         end else if (upd_w[c] < -36'sh80000000) begin
            upd_w[c] = -36'sh80000000; upd_sat = 1'b1;
         end
      end
      upd_word = {upd_w[2][31:0], upd_w[1][31:0], upd_w[0][31:0]};
   end

   // P1 and P2 take the clamped previous product straight from prod_ff
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_TMUL: begin mul_a = alpha_ff;  mul_b = req_ff.value_a; end
         S_YMUL: begin mul_a = tcl_w;     mul_b = LOG2E_Q; end
         S_WE:   begin mul_a = weight_ff; mul_b = e_ff; end
         S_P1:   begin mul_a = q_sat(prod_ff); mul_b = onep_w; end
         S_P2:   begin mul_a = q_sat(prod_ff); mul_b = grad_ff; end
         S_DX:   begin mul_a = p_ff;      mul_b = req_ff.deriv_x; end
         S_DY:   begin mul_a = p_ff;      mul_b = req_ff.deriv_y; end
         S_DZ:   begin mul_a = p_ff;      mul_b = req_ff.deriv_z; end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      case (state_ff)
         S_CLR:  if (clr_ff == SLOT_W'(MAX_SLOTS-1)) state_in = S_IDLE;
         S_IDLE: if (start) state_in = S_DISP;
         S_DISP: begin
            ch_in = '0;
            case (req_ff.mode)
               MODE_READ: state_in = S_RD;
               MODE_PAIR: state_in = req_ff.pair_valid ? S_CH : S_DONE;
               default:   state_in = S_DONE;
            endcase
         end
         S_RD:   state_in = S_RDW;
         S_RDW:  state_in = S_DONE;
         S_CH:   state_in = (ch_ff >= {1'b0, nch[CH_W-1:0]} && nch != 4'(MAX_CHANNELS))
                            || ch_ff == 4'(MAX_CHANNELS) ? S_NRD : S_TMUL;
         S_TMUL: state_in = S_T;
         S_T:    state_in = S_YMUL;
         S_YMUL: state_in = S_EXP;
         S_EXP:  state_in = S_EXPS;
         S_EXPS: state_in = S_WE;
         S_WE:   state_in = S_P1;
         S_P1:   state_in = S_P2;
         S_P2:   state_in = S_P3;
         S_P3:   state_in = S_DX;
         S_DX:   state_in = S_DY;
         S_DY:   state_in = S_DZ;
         S_DZ:   state_in = S_ACC;
         S_ACC:  begin state_in = S_CH; ch_in = ch_ff + 1'b1; end
         S_NRD:  state_in = S_NWB;
         S_NWB:  state_in = S_CRD;
         S_CRD:  state_in = S_CWB;
         S_CWB:  state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         clr_ff    <= '0;
         chans_ff  <= 4'd8;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == S_DONE);
         if (state_ff == S_CLR) clr_ff <= clr_ff + 1'b1;
         if (csr_we) chans_ff <= csr_wdata;
      end
   end

   // clocked memory accesses
   logic [SLOT_W-1:0] fadr;
   assign fadr = (state_ff == S_NRD || state_ff == S_NWB) ? req_ff.neighbor_slot
                                                         : req_ff.central_slot;
   always_ff @(posedge clock) begin
      if (state_ff == S_CLR)
         force_mem[clr_ff] <= '0;
      else if (state_ff == S_NWB || state_ff == S_CWB)
         force_mem[fadr] <= upd_word;
      frd_ff <= force_mem[fadr];
      if (state_ff == S_DISP && req_ff.mode == MODE_COEF) begin
         alpha_mem[{req_ff.neighbor_type, req_ff.channel}]  <= req_ff.value_a;
         weight_mem[{req_ff.neighbor_type, req_ff.channel}] <= req_ff.value_b;
      end
      if (state_ff == S_DISP && req_ff.mode == MODE_GRAD)
         grad_mem[req_ff.channel] <= req_ff.value_a;
      alpha_ff  <= alpha_mem[cidx];
      weight_ff <= weight_mem[cidx];
      grad_ff   <= grad_mem[ch_ff[CH_W-1:0]];
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) req_ff <= req_word;
      ch_ff   <= ch_in;
      prod_ff <= mul_p;
      case (state_ff)
         S_DISP: begin
            sat_ff <= 1'b0;
            for (int c = 0; c < 3; c++) sum_ff[c] <= '0;
         end
         S_T:    t_ff <= prod_ff[63:16];
         S_EXP:  e_ff <= (mexp_w > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF : mexp_w[31:0];
         S_P1:   p_ff <= q_sat(prod_ff);
         S_P2:   p_ff <= q_sat(prod_ff);
         S_P3:   p_ff <= q_sat(prod_ff) >>> 1;
         S_DY:   sum_ff[0] <= sum_ff[0] + 35'(q_sat(prod_ff));
         S_DZ:   sum_ff[1] <= sum_ff[1] + 35'(q_sat(prod_ff));
         S_ACC:  sum_ff[2] <= sum_ff[2] + 35'(q_sat(prod_ff));
         S_NWB, S_CWB: if (upd_sat) sat_ff <= 1'b1;
         default: ;
      endcase
      // product of w*e lands in prod_ff at S_P1 entry
      if (state_ff == S_DONE) begin
         rsp_ff.force_x   <= (req_ff.mode == MODE_READ) ? signed'(frd_ff[31:0]) : '0;
         rsp_ff.force_y   <= (req_ff.mode == MODE_READ) ? signed'(frd_ff[63:32]) : '0;
         rsp_ff.force_z   <= (req_ff.mode == MODE_READ) ? signed'(frd_ff[95:64]) : '0;
         rsp_ff.saturated <= (req_ff.mode == MODE_PAIR) & sat_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== tb/sv/tb_pair_force_scatter_accumulate.sv =====
// ----------------------------------------------------------------------------
// tb_pair_force_scatter_accumulate
// Drives coefficient loads, gradient loads, neighbor pairs and slot reads into
// the force scatter block, predicts each rsp word in Q16.16 and checks it.
// ----------------------------------------------------------------------------
module tb_pair_force_scatter_accumulate;
   import pfsa_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   logic         csr_we = 1'b0;
   logic [3:0]   csr_wdata = 4'd0;

   pair_force_scatter_accumulate DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   logic signed [31:0] alpha_q [NUM_TYPES*MAX_CHANNELS];
   logic signed [31:0] weight_q [NUM_TYPES*MAX_CHANNELS];
   logic signed [31:0] grad_q [MAX_CHANNELS];
   logic signed [31:0] force_mem [MAX_SLOTS][3];
   logic [3:0]         n_channels;

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   int           errors = 0;
   int           idle_pct = 0;
   bit           hold_off = 0;
   logic         busy_at_rise = 1'b1;

   localparam longint E2 [17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990,
      88752, 92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};

   // arithmetic shift on longint is a floor division by a power of two
   function automatic longint clamp32(longint x, ref bit hit);
      if (x > 64'sd2147483647) begin hit = 1; return 64'sd2147483647; end
      if (x < -64'sd2147483648) begin hit = 1; return -64'sd2147483648; end
      return x;
   endfunction

   function automatic longint qmul(longint a, longint b);
      bit dummy;
      return clamp32((a * b) >>> 16, dummy);
   endfunction

   function automatic longint exp_fixed(longint t);
      longint y, k, f, m;
      int j;
      bit dummy;
      if (t > 64'sd4194304) t = 64'sd4194304;
      if (t < -64'sd4194304) t = -64'sd4194304;
      y = (t * 94548) >>> 16;
      k = y >>> 16;
      f = y - k * 65536;
      j = int'(f >>> 12) & 15;
      m = E2[j] + (((E2[j+1] - E2[j]) * (f & 4095)) >>> 12);
      if (k >= 15) return 64'sd2147483647;
      if (k >= 0) return clamp32(m <<< k, dummy);
      if (k <= -32) return 0;
      return m >>> (-k);
   endfunction

   // advances the predicted state by one word and returns its rsp word
   function automatic rsp_word_type predict_force(req_word_type w);
      rsp_word_type r;
      longint sum [3];
      longint dv [3];
      longint t, p;
      int idx, n;
      bit hit;
      r = '0;
      hit = 0;
      case (w.mode)
         MODE_COEF: begin
            idx = w.neighbor_type * MAX_CHANNELS + w.channel;
            alpha_q[idx] = w.value_a;
            weight_q[idx] = w.value_b;
         end
         MODE_GRAD: grad_q[w.channel] = w.value_a;
         MODE_PAIR: begin
            if (w.pair_valid) begin
               n = (n_channels > MAX_CHANNELS) ? MAX_CHANNELS : n_channels;
               dv[0] = w.deriv_x; dv[1] = w.deriv_y; dv[2] = w.deriv_z;
               sum = '{0, 0, 0};
               for (int i = 0; i < n; i++) begin
                  idx = w.neighbor_type * MAX_CHANNELS + i;
                  t = (longint'(alpha_q[idx]) * longint'(w.value_a)) >>> 16;
                  p = qmul(weight_q[idx], exp_fixed(t));
                  p = qmul(p, clamp32(t + 65536, hit) );
                  p = qmul(p, grad_q[i]);
                  p = p >>> 1;
                  for (int c = 0; c < 3; c++) sum[c] += qmul(p, dv[c]);
               end
               hit = 0;   // the 1+t clamp does not count as a store clamp
               for (int c = 0; c < 3; c++)
                  force_mem[w.neighbor_slot][c] =
                     32'(clamp32(force_mem[w.neighbor_slot][c] + sum[c], hit));
               for (int c = 0; c < 3; c++)
                  force_mem[w.central_slot][c] =
                     32'(clamp32(force_mem[w.central_slot][c] - sum[c], hit));
               r.saturated = hit;
            end
         end
         default: begin
            r.force_x = force_mem[w.central_slot][0];
            r.force_y = force_mem[w.central_slot][1];
            r.force_z = force_mem[w.central_slot][2];
         end
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] rand_q();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'sh7FFFFFFF;
         2: return 32'sh80000000;
         default: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
      endcase
   endfunction

   function automatic req_word_type random_word(logic [1:0] mode);
      req_word_type w;
      w = '0;
      w.mode = mode;
      w.neighbor_type = 2'($urandom_range(0, 3));
      w.channel = 3'($urandom_range(0, 7));
      w.value_a = rand_q();
      w.value_b = rand_q();
      w.deriv_x = rand_q();
      w.deriv_y = rand_q();
      w.deriv_z = rand_q();
      w.central_slot = 8'($urandom_range(0, 255));
      w.neighbor_slot = 8'($urandom_range(0, 255));
      // keep slots mostly in a small set so that sums collide and saturate
      if ($urandom_range(0, 3) != 0) begin
         w.central_slot = 8'($urandom_range(0, 7));
         w.neighbor_slot = 8'($urandom_range(0, 7));
      end
      w.pair_valid = ($urandom_range(0, 9) != 0);
      return w;
   endfunction

   // a full table load so that pairs never touch an unwritten entry
   task automatic queue_tables();
      req_word_type w;
      for (int ty = 0; ty < NUM_TYPES; ty++)
         for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            w = random_word(MODE_COEF);
            w.neighbor_type = 2'(ty); w.channel = 3'(ch);
            // small alpha keeps exp in range for most pairs
            if ($urandom_range(0, 3) != 0)
               w.value_a = $signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000;
            pending_words.push_back(w);
         end
      for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
         w = random_word(MODE_GRAD);
         w.channel = 3'(ch);
         pending_words.push_back(w);
      end
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy_at_rise) begin
         // previous word taken at the last rising edge
         if (pending_words.size() != 0 && !hold_off && $urandom_range(1, 100) > idle_pct) begin
            req_word <= pending_words.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (pending_words.size() != 0 && !hold_off && $urandom_range(1, 100) > idle_pct) begin
            req_word <= pending_words.pop_front();
            start <= 1'b1;
         end
      end
   end

   // monitor: sample at the rising edge
   always @(posedge clock) begin
      busy_at_rise <= busy;
      if (!reset && start && !busy)
         expected_rsp.push_back(predict_force(req_word));
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected rsp word, actual %h", $time, rsp_word);
            errors++;
         end else begin
            rsp_word_type e;
            e = expected_rsp.pop_front();
            if (rsp_word.force_x !== e.force_x)
               $display("%0t: force_x expected %h actual %h", $time, e.force_x, rsp_word.force_x);
            if (rsp_word.force_y !== e.force_y)
               $display("%0t: force_y expected %h actual %h", $time, e.force_y, rsp_word.force_y);
            if (rsp_word.force_z !== e.force_z)
               $display("%0t: force_z expected %h actual %h", $time, e.force_z, rsp_word.force_z);
            if (rsp_word.saturated !== e.saturated)
               $display("%0t: saturated expected %b actual %b", $time, e.saturated,
                        rsp_word.saturated);
            if (rsp_word !== e) errors++;
         end
      end
   end

   task automatic drain();
      while (pending_words.size() != 0 || start || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_channels(logic [3:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      n_channels = v;
   endtask

   task automatic queue_random(int count);
      req_word_type w;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 9))
            0: w = random_word(MODE_COEF);
            1: w = random_word(MODE_GRAD);
            2, 3: w = random_word(MODE_READ);
            default: w = random_word(MODE_PAIR);
         endcase
         pending_words.push_back(w);
      end
   endtask

   initial begin
      req_word_type w;
      n_channels = 4'd8;
      for (int s = 0; s < MAX_SLOTS; s++) force_mem[s] = '{0, 0, 0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reads of cleared slots, full tables, extremes, padding, same slot
      w = '0; w.mode = MODE_READ; w.central_slot = 8'd255; pending_words.push_back(w);
      w.central_slot = 8'd0; pending_words.push_back(w);
      queue_tables();
      w = random_word(MODE_PAIR);
      w.pair_valid = 1'b0; pending_words.push_back(w);
      w.pair_valid = 1'b1; w.central_slot = 8'd5; w.neighbor_slot = 8'd5;
      pending_words.push_back(w);
      w.value_a = 32'sh7FFFFFFF; w.deriv_x = 32'sh80000000; w.neighbor_slot = 8'd255;
      w.central_slot = 8'd0; pending_words.push_back(w);
      w.value_a = 32'sh80000000; w.deriv_y = 32'sh7FFFFFFF; pending_words.push_back(w);
      w.mode = MODE_READ; w.central_slot = 8'd255; pending_words.push_back(w);
      w.central_slot = 8'd0; pending_words.push_back(w);
      drain();

      // phases over channel counts and idling
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: idle_pct = 0;
            1: idle_pct = 82;
            2: idle_pct = 0;
            default: idle_pct = 36;
         endcase
         case (ph)
            0: write_channels(4'd1);
            1: write_channels(4'd8);
            2: write_channels(4'd0);
            3: write_channels(4'd15);
            default: write_channels(4'($urandom_range(1, 8)));
         endcase
         queue_tables();
         queue_random(180);
         // sender holds until every expected word is back
         if (ph == 2) begin
            while (pending_words.size() > 90) @(posedge clock);
            hold_off = 1;
            while (start || expected_rsp.size() != 0) @(posedge clock);
            hold_off = 0;
         end
         drain();
      end

      if (errors == 0)
         $display("tb_pair_force_scatter_accumulate passed");
      else
         $display("tb_pair_force_scatter_accumulate failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_pair_force_scatter_accumulate failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/pfsa_pkg.sv
rtl/pair_force_scatter_accumulate.sv
tb/sv/tb_pair_force_scatter_accumulate.sv
